[design/ble_adv_data_parser_defines.svh]
// Assertion macros for the BLE advertising data parser.
// Used by ble_adv_data_parser.sv; expects signals clk and rst in scope.
`ifndef BLE_ADV_DATA_PARSER_DEFINES_SVH
`define BLE_ADV_DATA_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define BLEADP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BLEADP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLEADP_ASSERT(lbl, prop, msg)
`define BLEADP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[design/bleadp_pkg.sv]
// Shared widths, field codes and status codes of the BLE advertising data parser.
// No dependencies.
`timescale 1ns / 1ps

package bleadp_pkg;

  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS = 3'd0,
    KIND_FLAGS  = 3'd1,
    KIND_APPEAR = 3'd2,
    KIND_NAME   = 3'd3,
    KIND_MANUF  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_MISMATCH = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  localparam logic [BYTE_W-1:0] AD_FLAGS      = 8'h01;
  localparam logic [BYTE_W-1:0] AD_NAME_SHORT = 8'h08;
  localparam logic [BYTE_W-1:0] AD_NAME_FULL  = 8'h09;
  localparam logic [BYTE_W-1:0] AD_APPEARANCE = 8'h19;
  localparam logic [BYTE_W-1:0] AD_MANUF      = 8'hFF;

  localparam logic [BYTE_W-1:0] FLAGS_SIZE  = 8'd1;
  localparam logic [BYTE_W-1:0] APPEAR_SIZE = 8'd2;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic                field_start;
    logic                packet_done;
    status_t             status;
  } result_t;

endpackage

[design/bleadp_if.sv]
// Request channel interfaces of the BLE advertising data parser: payload bytes in,
// parse results out. Depends on bleadp_pkg.
`timescale 1ns / 1ps

interface bleadp_byte_if import bleadp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              end_of_packet;

  modport source (output valid, output payload_byte, output end_of_packet, input ready);
  modport sink (input valid, input payload_byte, input end_of_packet, output ready);
endinterface

interface bleadp_result_if import bleadp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [VALUE_W-1:0]  value;
  logic                field_start;
  logic                packet_done;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output kind, output value, output field_start,
                  output packet_done, output status, input ready);
  modport sink (input valid, input kind, input value, input field_start,
                input packet_done, input status, output ready);
endinterface

[design/ble_adv_data_parser.sv]
// BLE advertising data parser: one payload byte per request, one byte per cycle
// while the skid entry is empty; results go to the output register or skid entry.
// The parse state machine is updated as each byte is accepted; an output register
// plus one skid entry keep input taking bytes while a result waits downstream.
// Synchronous active-high reset returns the parse state to "expect length byte"
// and empties the output register and skid entry.
// Depends on bleadp_pkg, bleadp_if and ble_adv_data_parser_defines.svh.
`timescale 1ns / 1ps
`include "ble_adv_data_parser_defines.svh"

module ble_adv_data_parser import bleadp_pkg::*; (
  input logic clk,
  input logic rst,
  bleadp_byte_if.sink     bytes,
  bleadp_result_if.source results
);

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_DATA,
    PH_IGNORE
  } phase_t;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] bytes_left, bytes_left_next;
  kind_t             field_class, field_class_next;
  logic [BYTE_W-1:0] low_byte_hold, low_byte_hold_next;
  status_t           sticky_status, sticky_status_next;
  logic              first_pending, first_pending_next;

  result_t out_reg, skid_reg, res_next;
  logic    out_valid, skid_valid;
  logic    accept, emit, res_valid;
  logic [BYTE_W-1:0] b;
  logic    last;

  assign b      = bytes.payload_byte;
  assign last   = bytes.end_of_packet;
  assign accept = bytes.valid && bytes.ready;
  assign bytes.ready = !skid_valid;

  always_comb begin
    logic [BYTE_W-1:0] dec;
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    field_class_next   = field_class;
    low_byte_hold_next = low_byte_hold;
    sticky_status_next = sticky_status;
    first_pending_next = first_pending;
    emit               = 1'b0;
    res_next.kind        = KIND_STATUS;
    res_next.value       = '0;
    res_next.field_start = 1'b0;
    res_next.packet_done = last;
    res_next.status      = ST_OK;
    dec = (bytes_left != '0) ? bytes_left - 8'd1 : bytes_left;

    unique case (phase)
      PH_LEN: begin
        if (b == '0) begin
          phase_next = PH_IGNORE;
        end else begin
          bytes_left_next = b - 8'd1;
          phase_next      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        priority if (b == AD_FLAGS) begin
          field_class_next = KIND_FLAGS;
        end else if (b == AD_APPEARANCE) begin
          field_class_next = KIND_APPEAR;
        end else if (b == AD_NAME_SHORT || b == AD_NAME_FULL) begin
          field_class_next   = KIND_NAME;
          first_pending_next = 1'b1;
        end else if (b == AD_MANUF) begin
          field_class_next   = KIND_MANUF;
          first_pending_next = 1'b1;
        end else begin
          field_class_next = KIND_STATUS;
          if (sticky_status == ST_OK) begin
            sticky_status_next = ST_UNKNOWN;
          end
        end
        if ((b == AD_FLAGS && bytes_left != FLAGS_SIZE) ||
            (b == AD_APPEARANCE && bytes_left != APPEAR_SIZE)) begin
          sticky_status_next = ST_MISMATCH;
          phase_next         = PH_IGNORE;
        end else begin
          phase_next = (bytes_left == '0) ? PH_LEN : PH_DATA;
        end
      end
      PH_DATA: begin
        unique case (field_class)
          KIND_FLAGS: begin
            emit           = 1'b1;
            res_next.kind  = KIND_FLAGS;
            res_next.value = {8'd0, b};
          end
          KIND_APPEAR: begin
            if (bytes_left == APPEAR_SIZE) begin
              low_byte_hold_next = b;
            end else begin
              emit           = 1'b1;
              res_next.kind  = KIND_APPEAR;
              res_next.value = {b, low_byte_hold};
            end
          end
          KIND_NAME, KIND_MANUF: begin
            emit                 = 1'b1;
            res_next.kind        = field_class;
            res_next.value       = {8'd0, b};
            res_next.field_start = first_pending;
            first_pending_next   = 1'b0;
          end
          default: begin
          end
        endcase
        bytes_left_next = dec;
        if (dec == '0) begin
          phase_next = PH_LEN;
        end
      end
      PH_IGNORE: begin
      end
    endcase

    if (last) begin
      if (sticky_status_next != ST_MISMATCH &&
          (phase_next == PH_TYPE || phase_next == PH_DATA)) begin
        res_next.status = ST_TRUNC;
      end else begin
        res_next.status = sticky_status_next;
      end
      phase_next         = PH_LEN;
      bytes_left_next    = '0;
      field_class_next   = KIND_STATUS;
      low_byte_hold_next = '0;
      sticky_status_next = ST_OK;
      first_pending_next = 1'b0;
    end
    res_valid = accept && (emit || last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEN;
      bytes_left    <= '0;
      field_class   <= KIND_STATUS;
      low_byte_hold <= '0;
      sticky_status <= ST_OK;
      first_pending <= 1'b0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        bytes_left    <= bytes_left_next;
        field_class   <= field_class_next;
        low_byte_hold <= low_byte_hold_next;
        sticky_status <= sticky_status_next;
        first_pending <= first_pending_next;
      end
      if (!out_valid || results.ready) begin
        if (skid_valid) begin
          out_reg    <= skid_reg;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_reg   <= res_next;
          out_valid <= res_valid;
        end
      end else if (res_valid) begin
        skid_reg   <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign results.valid       = out_valid;
  assign results.kind        = out_reg.kind;
  assign results.value       = out_reg.value;
  assign results.field_start = out_reg.field_start;
  assign results.packet_done = out_reg.packet_done;
  assign results.status      = out_reg.status;

  `BLEADP_ASSERT(a_skid_behind_out, skid_valid |-> out_valid, "skid entry held without output")
  `BLEADP_ASSERT(a_last_resets, (accept && last) |=> (phase == PH_LEN && sticky_status == ST_OK), "parse state not cleared after last byte")
  `BLEADP_ASSERT(a_status_only_at_end, (out_valid && !out_reg.packet_done) |-> (out_reg.status == ST_OK), "status reported before end of packet")
  `BLEADP_ASSERT(a_start_kind, (out_valid && out_reg.field_start) |-> (out_reg.kind == KIND_NAME || out_reg.kind == KIND_MANUF), "field start on wrong kind")
  `BLEADP_ASSERT_RST(a_reset_empty, rst |=> (!out_valid && !skid_valid), "result buffers not empty after reset")

endmodule
